[hw/rtl/lglw_pkg.sv]
// ----------------------------------------------------------------------------
// lglw_pkg
// Types, constants and helper functions shared by the log grid Lagrange
// weight pipeline.
// ----------------------------------------------------------------------------
package lglw_pkg;

    localparam int MAX_DEGREE_DEF = 8;
    localparam int DEG_W          = 4;
    localparam int FRAC_W         = 20;
    localparam int WMAG_W         = 38;
    localparam int RECIP_S        = 29;
    localparam int RECIP_W        = 30;

    localparam logic [WMAG_W-1:0] W_LIMIT = {WMAG_W{1'b1}};
    localparam logic [WMAG_W-1:0] Q24_ONE = WMAG_W'(64'd1 << 24);

    localparam logic [31:0] INV_STEP_RST = 32'h0010_0000;
    localparam logic [15:0] INT_CNT_RST  = 16'd0;
    localparam logic [3:0]  DEGREE_RST   = 4'd3;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_STEP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INT_CNT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEGREE   = 2'd2;

    localparam logic [63:0] RECIP_NUM = 64'd1 << RECIP_S;

    typedef struct packed {
        logic [FRAC_W-1:0] frac;
        logic [DEG_W-1:0]  j;
        logic [DEG_W-1:0]  id;
        logic              hit;
        logic              sup;
        logic              w_neg;
        logic [WMAG_W-1:0] w_mag;
    } t_item;

    // ceil(2^29 / d) for the small window divisors
    function automatic logic [RECIP_W-1:0] recip(input logic [DEG_W-1:0] d);
        logic [RECIP_W-1:0] m;
        case (d)
            4'd1:    m = RECIP_W'(RECIP_NUM);
            4'd2:    m = RECIP_W'((RECIP_NUM + 64'd1) / 64'd2);
            4'd3:    m = RECIP_W'((RECIP_NUM + 64'd2) / 64'd3);
            4'd4:    m = RECIP_W'((RECIP_NUM + 64'd3) / 64'd4);
            4'd5:    m = RECIP_W'((RECIP_NUM + 64'd4) / 64'd5);
            4'd6:    m = RECIP_W'((RECIP_NUM + 64'd5) / 64'd6);
            4'd7:    m = RECIP_W'((RECIP_NUM + 64'd6) / 64'd7);
            4'd8:    m = RECIP_W'((RECIP_NUM + 64'd7) / 64'd8);
            4'd9:    m = RECIP_W'((RECIP_NUM + 64'd8) / 64'd9);
            4'd10:   m = RECIP_W'((RECIP_NUM + 64'd9) / 64'd10);
            4'd11:   m = RECIP_W'((RECIP_NUM + 64'd10) / 64'd11);
            4'd12:   m = RECIP_W'((RECIP_NUM + 64'd11) / 64'd12);
            4'd13:   m = RECIP_W'((RECIP_NUM + 64'd12) / 64'd13);
            4'd14:   m = RECIP_W'((RECIP_NUM + 64'd13) / 64'd14);
            4'd15:   m = RECIP_W'((RECIP_NUM + 64'd14) / 64'd15);
            default: m = '0;
        endcase
        return m;
    endfunction

endpackage

[hw/rtl/log_grid_lagrange_weight_unit.sv]
// ----------------------------------------------------------------------------
// log_grid_lagrange_weight_unit
// Lagrange basis weight of one node on a uniform log grid, Q8.24 result.
// ----------------------------------------------------------------------------
// Stages run F1, F2, F3, the factor chain, then the output register.
// Throughput: one request per cycle; one 5-stage factor unit per window node.
// A stalled output holds the whole pipeline.
// Synchronous active-low reset clears valids and loads register defaults.
// ----------------------------------------------------------------------------
module log_grid_lagrange_weight_unit
    import lglw_pkg::*;
#(
    parameter int MAX_DEGREE = MAX_DEGREE_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_wdata,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic signed [15:0]   i_node_index,
    input  logic signed [31:0]   i_log_x,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic signed [31:0]   o_weight,
    output logic                 o_in_support
);

    localparam int NF = MAX_DEGREE + 1;

    logic [31:0]      r_inv_step;
    logic [15:0]      r_int_cnt;
    logic [DEG_W-1:0] r_degree;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_step <= INV_STEP_RST;
            r_int_cnt  <= INT_CNT_RST;
            r_degree   <= DEGREE_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_INV_STEP: r_inv_step <= i_cfg_wdata;
                CFG_INT_CNT:  r_int_cnt  <= i_cfg_wdata[15:0];
                CFG_DEGREE:   r_degree   <= i_cfg_wdata[DEG_W-1:0];
                default: ;
            endcase
        end
    end

    logic en;
    logic r_out_valid;

    assign en         = !(r_out_valid && i_out_stall);
    assign o_in_stall = !en;

    // F1: log_x * inv_step
    logic signed [64:0] f1_prod;
    assign f1_prod = $signed(i_log_x) * $signed({1'b0, r_inv_step});

    logic               r_f1_valid;
    logic [63:0]        r_f1_prod;
    logic signed [15:0] r_f1_beta;

    // F2: ix in Q.20
    logic signed [44:0] f2_ix;
    assign f2_ix = 45'($signed(r_f1_prod[63:20])) + $signed({5'b0, r_int_cnt, 20'b0});

    logic               r_f2_valid;
    logic signed [44:0] r_f2_ix;
    logic signed [15:0] r_f2_beta;

    // F3: support test and window position
    logic signed [25:0] f3_diff;
    logic [DEG_W-1:0]   f3_id;
    t_item              f3_item;

    assign f3_diff = 26'(r_f2_beta) - 26'($signed(r_f2_ix[44:20]));
    assign f3_id   = (r_degree > DEG_W'(MAX_DEGREE)) ? DEG_W'(MAX_DEGREE) : r_degree;

    always_comb begin
        f3_item       = '0;
        f3_item.frac  = r_f2_ix[19:0];
        f3_item.j     = f3_diff[DEG_W-1:0];
        f3_item.id    = f3_id;
        f3_item.sup   = !f3_diff[25] && (f3_diff <= 26'(f3_id));
        f3_item.hit   = (f3_diff == '0) && (r_f2_ix[19:0] == '0);
        f3_item.w_neg = 1'b0;
        f3_item.w_mag = Q24_ONE;
    end

    logic  r_f3_valid;
    t_item r_f3_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_valid <= 1'b0;
            r_f2_valid <= 1'b0;
            r_f3_valid <= 1'b0;
        end else if (en) begin
            r_f1_valid <= i_in_valid;
            r_f2_valid <= r_f1_valid;
            r_f3_valid <= r_f2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f1_prod <= f1_prod[63:0];
            r_f1_beta <= i_node_index;
            r_f2_ix   <= f2_ix;
            r_f2_beta <= r_f1_beta;
            r_f3_item <= f3_item;
        end
    end

    // factor chain
    logic  fc_valid [NF+1];
    t_item fc_item  [NF+1];

    assign fc_valid[0] = r_f3_valid;
    assign fc_item[0]  = r_f3_item;

    for (genvar k = 0; k < NF; k++) begin : g_fac
        lglw_factor #(
            .K(k)
        ) u_fac (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (fc_valid[k]),
            .i_item  (fc_item[k]),
            .o_valid (fc_valid[k+1]),
            .o_item  (fc_item[k+1])
        );
    end

    // output stage
    t_item       fo;
    logic [31:0] fo_weight;

    assign fo = fc_item[NF];

    always_comb begin
        if (!fo.sup) begin
            fo_weight = '0;
        end else if (fo.hit) begin
            fo_weight = 32'h0100_0000;
        end else if (!fo.w_neg) begin
            fo_weight = (fo.w_mag > 38'h00_7FFF_FFFF) ? 32'h7FFF_FFFF : fo.w_mag[31:0];
        end else begin
            fo_weight = (fo.w_mag >= 38'h00_8000_0000) ? 32'h8000_0000
                                                       : (32'd0 - fo.w_mag[31:0]);
        end
    end

    logic [31:0] r_out_weight;
    logic        r_out_sup;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= fc_valid[NF];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_weight <= fo_weight;
            r_out_sup    <= fo.sup;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_weight     = $signed(r_out_weight);
    assign o_in_support = r_out_sup;

endmodule

[hw/rtl/lglw_factor.sv]
// ----------------------------------------------------------------------------
// lglw_factor
// One window factor: w * (ix - d) / ((node - d) * 2^20), rounded, clamped.
// Five register stages: multiply, round/saturate, high digit, remainder,
// low digit.
// ----------------------------------------------------------------------------
module lglw_factor
    import lglw_pkg::*;
#(
    parameter int K = 0
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_item i_item,
    output logic  o_valid,
    output t_item o_item
);

    localparam logic [DEG_W-1:0] KV = DEG_W'(K);

    // stage A
    logic              a_act;
    logic [23:0]       a_nummag;
    logic [DEG_W-1:0]  a_den;
    logic              a_neg;
    logic [61:0]       a_pm;

    assign a_act    = i_item.sup && !i_item.hit && (KV <= i_item.id) && (KV != i_item.j);
    assign a_nummag = (K == 0) ? {4'b0, i_item.frac} : ({KV, 20'b0} - {4'b0, i_item.frac});
    assign a_den    = (i_item.j >= KV) ? (i_item.j - KV) : (KV - i_item.j);
    assign a_neg    = i_item.w_neg ^ (K != 0) ^ (i_item.j < KV);
    assign a_pm     = 62'(i_item.w_mag) * 62'(a_nummag);

    logic             r_a_valid, r_a_act, r_a_neg;
    t_item            r_a_item;
    logic [DEG_W-1:0] r_a_den;
    logic [61:0]      r_a_pm;

    // stage B
    logic [62:0] b_sum;
    logic [42:0] b_t;
    logic        b_sat;

    assign b_sum = 63'(r_a_pm) + 63'({r_a_den, 19'b0});
    assign b_t   = b_sum[62:20];
    assign b_sat = b_t >= 43'({r_a_den, 38'b0});

    logic             r_b_valid, r_b_act, r_b_neg, r_b_sat;
    t_item            r_b_item;
    logic [DEG_W-1:0] r_b_den;
    logic [41:0]      r_b_t;

    // stage C
    logic [50:0] c_prod;

    assign c_prod = 51'(r_b_t[41:21]) * 51'(recip(r_b_den));

    logic             r_c_valid, r_c_act, r_c_neg, r_c_sat;
    t_item            r_c_item;
    logic [DEG_W-1:0] r_c_den;
    logic [20:0]      r_c_qh, r_c_th, r_c_tl;

    // stage D
    logic [24:0] d_qd;
    logic [20:0] d_rh;

    assign d_qd = 25'(r_c_qh) * 25'(r_c_den);
    assign d_rh = r_c_th - d_qd[20:0];

    logic             r_d_valid, r_d_act, r_d_neg, r_d_sat;
    t_item            r_d_item;
    logic [DEG_W-1:0] r_d_den;
    logic [20:0]      r_d_qh;
    logic [24:0]      r_d_v;

    // stage E
    logic [54:0] e_prod;
    logic [41:0] e_q;
    t_item       e_item;

    assign e_prod = 55'(r_d_v) * 55'(recip(r_d_den));
    assign e_q    = {r_d_qh, 21'b0} + 42'(e_prod[53:29]);

    always_comb begin
        e_item = r_d_item;
        if (r_d_act) begin
            e_item.w_neg = r_d_neg;
            e_item.w_mag = r_d_sat ? W_LIMIT : e_q[WMAG_W-1:0];
        end
    end

    logic  r_e_valid;
    t_item r_e_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
            r_e_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
            r_d_valid <= r_c_valid;
            r_e_valid <= r_d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_item <= i_item;
            r_a_act  <= a_act;
            r_a_neg  <= a_neg;
            r_a_den  <= a_den;
            r_a_pm   <= a_pm;

            r_b_item <= r_a_item;
            r_b_act  <= r_a_act;
            r_b_neg  <= r_a_neg;
            r_b_den  <= r_a_den;
            r_b_sat  <= b_sat;
            r_b_t    <= b_t[41:0];

            r_c_item <= r_b_item;
            r_c_act  <= r_b_act;
            r_c_neg  <= r_b_neg;
            r_c_den  <= r_b_den;
            r_c_sat  <= r_b_sat;
            r_c_qh   <= c_prod[49:29];
            r_c_th   <= r_b_t[41:21];
            r_c_tl   <= r_b_t[20:0];

            r_d_item <= r_c_item;
            r_d_act  <= r_c_act;
            r_d_neg  <= r_c_neg;
            r_d_den  <= r_c_den;
            r_d_sat  <= r_c_sat;
            r_d_qh   <= r_c_qh;
            r_d_v    <= {d_rh[3:0], r_c_tl};

            r_e_item <= e_item;
        end
    end

    assign o_valid = r_e_valid;
    assign o_item  = r_e_item;

endmodule
